/* rtl/egpe_pkg.sv */
`timescale 1ns / 1ps

package egpe_pkg;

  // Register indexes of the configuration port.
  localparam int unsigned CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_COEF_COS          = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COEF_SIN          = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_INV_AXIS_RATIO_SQ = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_NORM              = 8'd3;

  localparam logic [31:0] INV_AXIS_RATIO_SQ_RST = 32'd16777216;

  // Magnitudes of the rotated offsets in Q.16; anything at 64.0 or above is flagged.
  localparam int unsigned AB_W = 22;
  // Quadratic form in Q.32, below 32.0 when it is used.
  localparam int unsigned Q_W = 37;
  // Exponent in base two, Q6.24.
  localparam int unsigned T_W = 30;
  localparam int unsigned T_FRAC_W = 24;
  localparam int unsigned SHIFT_W = T_W - T_FRAC_W;
  // Mantissa of exp, Q.30 with 1.0 representable.
  localparam int unsigned MANT_W = 31;

  localparam int unsigned MAX_TABLE_BITS = 12;

  localparam logic [MANT_W-1:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [63:0] ONE_Q30  = 64'h0000_0000_4000_0000;
  localparam logic [63:0] HALF_Q30 = 64'h0000_0000_2000_0000;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bit_v;
    rem   = v;
    res   = '0;
    bit_v = 64'h4000_0000_0000_0000;
    for (int it = 0; it < 32; it++) begin
      if (rem >= res + bit_v) begin
        rem = rem - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // Entry idx of the table of 2^(-idx/2^bits), built from repeated square roots of one half.
  function automatic logic [MANT_W-1:0] exp_rom_entry(input int bits, input int idx);
    logic [63:0] roots [0:MAX_TABLE_BITS];
    logic [63:0] v;
    roots[0] = ONE_Q30 >> 1;
    for (int k = 1; k <= bits; k++) begin
      roots[k] = isqrt64(roots[k-1] << 30);
    end
    v = ONE_Q30;
    for (int j = 0; j <= bits; j++) begin
      if (((idx >> j) & 1) != 0) begin
        v = (v * roots[bits-j] + HALF_Q30) >> 30;
      end
    end
    return v[MANT_W-1:0];
  endfunction

endpackage

/* rtl/egpe_pixel_if.sv */
`timescale 1ns / 1ps

interface egpe_pixel_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] dx;
  logic signed [31:0] dy;

  modport source (output valid, output dx, output dy, input ready);
  modport sink (input valid, input dx, input dy, output ready);
endinterface

/* rtl/egpe_result_if.sv */
`timescale 1ns / 1ps

interface egpe_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] intensity;

  modport source (output valid, output intensity, input ready);
  modport sink (input valid, input intensity, output ready);
endinterface

/* rtl/egpe_rotate.sv */
`timescale 1ns / 1ps

module egpe_rotate import egpe_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic signed [31:0]  coef_cos,
  input  logic signed [31:0]  coef_sin,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  dx,
  input  logic signed [31:0]  dy,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [AB_W-1:0]     am,
  output logic [AB_W-1:0]     bm,
  output logic                big
);

  localparam int unsigned NS = 3;

  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  logic signed [63:0] p_xc;
  logic signed [63:0] p_ys;
  logic signed [63:0] p_xs;
  logic signed [63:0] p_yc;
  logic signed [64:0] sa;
  logic signed [64:0] sb;
  logic        [64:0] ma;
  logic        [64:0] mb;

  // A stage takes a new item when it is empty or its contents move on.
  always_comb begin
    en[NS-1] = ~vld[NS-1] | out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = ~vld[k] | en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_comb begin
    ma = sa[64] ? 65'(-sa) : 65'(sa);
    mb = sb[64] ? 65'(-sb) : 65'(sb);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_xc <= dx * coef_cos;
      p_ys <= dy * coef_sin;
      p_xs <= dx * coef_sin;
      p_yc <= dy * coef_cos;
    end
    if (en[1]) begin
      sa <= 65'(p_xc) + 65'(p_ys);
      sb <= 65'(p_xs) - 65'(p_yc);
    end
    if (en[2]) begin
      am  <= ma[24 +: AB_W];
      bm  <= mb[24 +: AB_W];
      big <= (|ma[64:24+AB_W]) | (|mb[64:24+AB_W]);
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NS-1];

endmodule

/* rtl/egpe_quad.sv */
`timescale 1ns / 1ps

module egpe_quad import egpe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [31:0]       inv_axis_ratio_sq,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [AB_W-1:0]   am,
  input  logic [AB_W-1:0]   bm,
  input  logic              big,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [Q_W-1:0]    q,
  output logic              zero
);

  localparam int unsigned NS = 3;
  localparam int unsigned SQ_W = 2 * AB_W;
  localparam int unsigned BS_W = SQ_W - 16;
  localparam int unsigned BI_W = BS_W + 32;
  localparam int unsigned QS_W = BI_W - 8 + 1;

  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  logic [SQ_W-1:0] aa0;
  logic [SQ_W-1:0] bb0;
  logic            z0;
  logic [SQ_W-1:0] aa1;
  logic [BI_W-1:0] bbi1;
  logic            z1;
  logic [QS_W-1:0] qs;

  always_comb begin
    en[NS-1] = ~vld[NS-1] | out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = ~vld[k] | en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign qs = QS_W'(aa1) + QS_W'(bbi1[BI_W-1:8]);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      aa0 <= SQ_W'(am) * SQ_W'(am);
      bb0 <= SQ_W'(bm) * SQ_W'(bm);
      z0  <= big;
    end
    if (en[1]) begin
      aa1  <= aa0;
      bbi1 <= BI_W'(bb0[SQ_W-1:16]) * BI_W'(inv_axis_ratio_sq);
      z1   <= z0;
    end
    if (en[2]) begin
      q    <= qs[Q_W-1:0];
      // The exponential underflows once the form reaches 32.
      zero <= z1 | (|qs[QS_W-1:Q_W]);
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NS-1];

endmodule

/* rtl/egpe_exp.sv */
`timescale 1ns / 1ps

module egpe_exp import egpe_pkg::*; #(
  parameter int unsigned EXP_TABLE_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [31:0]       norm,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [Q_W-1:0]    q,
  input  logic              zero,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       intensity
);

  localparam int unsigned NS = 5;
  localparam int unsigned ROM_SIZE = (1 << EXP_TABLE_BITS) + 1;
  localparam int unsigned SH = T_FRAC_W - EXP_TABLE_BITS;
  localparam int unsigned TP_W = (Q_W - 8) + MANT_W;
  localparam int unsigned DP_W = MANT_W + SH;

  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  logic [MANT_W-1:0] rom [ROM_SIZE];

  logic [TP_W-1:0]         tp;
  logic [T_W-1:0]          t0;
  logic                    z0;
  logic [EXP_TABLE_BITS:0] idx_lo;
  logic [EXP_TABLE_BITS:0] idx_hi;
  logic [MANT_W-1:0]       lo;
  logic [MANT_W-1:0]       hi;
  logic [MANT_W-1:0]       lo1;
  logic [MANT_W-1:0]       d1;
  logic [SH-1:0]           frac1;
  logic [SHIFT_W-1:0]      n1;
  logic                    z1;
  logic [DP_W-1:0]         dp;
  logic [MANT_W-1:0]       m2;
  logic [SHIFT_W-1:0]      n2;
  logic                    z2;
  logic [MANT_W-1:0]       e3;
  logic                    z3;
  logic [63:0]             pr;
  logic [33:0]             r;

  for (genvar gi = 0; gi < ROM_SIZE; gi++) begin : g_rom
    assign rom[gi] = exp_rom_entry(EXP_TABLE_BITS, gi);
  end

  always_comb begin
    en[NS-1] = ~vld[NS-1] | out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = ~vld[k] | en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // exp(-q) = 2^(-q*log2(e)); the integer part of the exponent becomes a right shift.
  assign tp = TP_W'(q[Q_W-1:8]) * TP_W'(LOG2E_Q30);

  always_comb begin
    idx_lo = {1'b0, t0[T_FRAC_W-1 -: EXP_TABLE_BITS]};
    idx_hi = idx_lo + 1'b1;
    lo     = rom[idx_lo];
    hi     = rom[idx_hi];
  end

  assign dp = DP_W'(d1) * DP_W'(frac1);
  assign pr = 64'(norm) * 64'(e3) + HALF_Q30;
  assign r  = pr[63:30];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t0 <= tp[30 +: T_W];
      z0 <= zero;
    end
    if (en[1]) begin
      lo1   <= lo;
      d1    <= (lo >= hi) ? MANT_W'(lo - hi) : '0;
      frac1 <= t0[SH-1:0];
      n1    <= t0[T_W-1:T_FRAC_W];
      z1    <= z0;
    end
    if (en[2]) begin
      m2 <= lo1 - dp[DP_W-1:SH];
      n2 <= n1;
      z2 <= z1;
    end
    if (en[3]) begin
      e3 <= m2 >> n2;
      z3 <= z2;
    end
    if (en[4]) begin
      if (z3) begin
        intensity <= '0;
      end else if (|r[33:32]) begin
        intensity <= '1;
      end else begin
        intensity <= r[31:0];
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NS-1];

endmodule

/* rtl/elliptical_gaussian_pixel_eval_top.sv */
`timescale 1ns / 1ps

// Evaluates a rotated elliptical Gaussian at one pixel per item.
// The pixel channel carries the offset (dx, dy) of a pixel centre from the
// profile centre in signed Q15.16; the result channel carries one intensity
// per pixel, unsigned Q16.16, in the order the pixels arrived.
// Both channels use valid/ready; an item moves when both are high.
// The configuration port writes coef_cos, coef_sin, inv_axis_ratio_sq and
// norm by index; write it only while no pixel is in flight.
// The pipeline has eleven register stages: rotation (3), quadratic form (3)
// and the exp and scale unit (5). One pixel is accepted per cycle unless the
// pipeline is full and the receiver stalls.
// When the receiver stalls, each stage holds its item and empty stages keep
// filling, so pixels are still taken until the pipeline is full.
// Synchronous reset empties the pipeline and loads the register defaults
// (coefficients and norm zero, inverse axis ratio squared 1.0).
module elliptical_gaussian_pixel_eval_top import egpe_pkg::*; #(
  parameter int unsigned EXP_TABLE_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  egpe_pixel_if.sink             pixel,
  egpe_result_if.source          result,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data
);

  logic signed [31:0] coef_cos;
  logic signed [31:0] coef_sin;
  logic        [31:0] inv_axis_ratio_sq;
  logic        [31:0] norm;

  logic            rot_valid;
  logic            rot_ready;
  logic [AB_W-1:0] am;
  logic [AB_W-1:0] bm;
  logic            big;
  logic            quad_valid;
  logic            quad_ready;
  logic [Q_W-1:0]  q;
  logic            zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_cos          <= '0;
      coef_sin          <= '0;
      inv_axis_ratio_sq <= INV_AXIS_RATIO_SQ_RST;
      norm              <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_COEF_COS:          coef_cos          <= cfg_data;
        CFG_COEF_SIN:          coef_sin          <= cfg_data;
        CFG_INV_AXIS_RATIO_SQ: inv_axis_ratio_sq <= cfg_data;
        CFG_NORM:              norm              <= cfg_data;
        default: ;
      endcase
    end
  end

  egpe_rotate u_rotate (
    .clk       (clk),
    .rst       (rst),
    .coef_cos  (coef_cos),
    .coef_sin  (coef_sin),
    .in_valid  (pixel.valid),
    .in_ready  (pixel.ready),
    .dx        (pixel.dx),
    .dy        (pixel.dy),
    .out_valid (rot_valid),
    .out_ready (rot_ready),
    .am        (am),
    .bm        (bm),
    .big       (big)
  );

  egpe_quad u_quad (
    .clk               (clk),
    .rst               (rst),
    .inv_axis_ratio_sq (inv_axis_ratio_sq),
    .in_valid          (rot_valid),
    .in_ready          (rot_ready),
    .am                (am),
    .bm                (bm),
    .big               (big),
    .out_valid         (quad_valid),
    .out_ready         (quad_ready),
    .q                 (q),
    .zero              (zero)
  );

  egpe_exp #(
    .EXP_TABLE_BITS (EXP_TABLE_BITS)
  ) u_exp (
    .clk       (clk),
    .rst       (rst),
    .norm      (norm),
    .in_valid  (quad_valid),
    .in_ready  (quad_ready),
    .q         (q),
    .zero      (zero),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .intensity (result.intensity)
  );

endmodule

/* bench/elliptical_gaussian_pixel_eval_top_tb.sv */
`timescale 1ns / 1ps

module elliptical_gaussian_pixel_eval_top_tb;

  typedef longint unsigned u64_t;

  localparam int unsigned TABLE_BITS = 8;
  localparam int unsigned TABLE_LAST = 1 << TABLE_BITS;
  localparam int unsigned FRAC_SHIFT = 24 - TABLE_BITS;
  localparam u64_t Q30_ONE = 64'd1 << 30;
  localparam u64_t LOG2_E_Q30 = 64'd1549082005;
  localparam u64_t AB_LIMIT = 64'd1 << 22;
  localparam u64_t Q_LIMIT = 64'd32 << 32;
  localparam logic [31:0] Q24_ONE = 32'h0100_0000;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 225;

  // Indexes that map to no register; writes to them must leave everything alone.
  localparam logic [egpe_pkg::CFG_INDEX_W-1:0] CFG_SPARE_LO = 8'd4;
  localparam logic [egpe_pkg::CFG_INDEX_W-1:0] CFG_SPARE_HI = 8'hFF;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [egpe_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  egpe_pixel_if pixel_ch();
  egpe_result_if result_ch();

  elliptical_gaussian_pixel_eval_top #(
    .EXP_TABLE_BITS(TABLE_BITS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .pixel(pixel_ch),
    .result(result_ch),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow of the block's registers, at their reset values.
  logic signed [31:0] gauss_cos = '0;
  logic signed [31:0] gauss_sin = '0;
  logic [31:0] gauss_inv_ar2 = egpe_pkg::INV_AXIS_RATIO_SQ_RST;
  logic [31:0] gauss_norm = '0;

  u64_t exp2_rom [0:TABLE_LAST];
  logic [31:0] intensity_q [$];
  logic [31:0] want_intensity;
  bit steady = 1'b0;
  int errors = 0;
  int pixels_sent = 0;
  int results_seen = 0;
  int nonzero_seen = 0;
  int settings_used = 0;
  int stall_cycles = 0;

  // Table of 2^(-i/2^TABLE_BITS) in Q.30, from repeated square roots of one half.
  initial begin : exp2_table_build
    u64_t root [0:TABLE_BITS];
    u64_t v;
    u64_t res;
    u64_t bit_v;
    root[0] = Q30_ONE >> 1;
    for (int k = 1; k <= TABLE_BITS; k++) begin
      v = root[k-1] << 30;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > v) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
        if (v >= res + bit_v) begin
          v = v - (res + bit_v);
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v = bit_v >> 2;
      end
      root[k] = res;
    end
    for (int i = 0; i <= TABLE_LAST; i++) begin
      v = Q30_ONE;
      for (int j = 0; j <= TABLE_BITS; j++) begin
        if (((i >> j) & 1) != 0) begin
          v = (v * root[TABLE_BITS-j] + (Q30_ONE >> 1)) >> 30;
        end
      end
      exp2_rom[i] = v;
    end
  end

  function automatic u64_t mag_of_sum(input longint p1, input longint p2);
    u64_t u1;
    u64_t u2;
    u1 = (p1 < 0) ? u64_t'(-p1) : u64_t'(p1);
    u2 = (p2 < 0) ? u64_t'(-p2) : u64_t'(p2);
    if ((p1 < 0) == (p2 < 0)) return u1 + u2;
    return (u1 >= u2) ? u1 - u2 : u2 - u1;
  endfunction

  function automatic logic [31:0] predict_intensity(input logic signed [31:0] x,
                                                    input logic signed [31:0] y);
    u64_t am, bm, q, t, n, f, idx, frac, d, m, e, r;
    am = mag_of_sum(longint'(x) * longint'(gauss_cos), longint'(y) * longint'(gauss_sin)) >> 24;
    bm = mag_of_sum(longint'(x) * longint'(gauss_sin),
                    -(longint'(y) * longint'(gauss_cos))) >> 24;
    if (am >= AB_LIMIT || bm >= AB_LIMIT) return '0;
    q = am * am + ((((bm * bm) >> 16) * u64_t'(gauss_inv_ar2)) >> 8);
    if (q >= Q_LIMIT) return '0;
    // exp(-q) = 2^(-q*log2(e)); integer part shifts, fraction goes through the table.
    t = ((q >> 8) * LOG2_E_Q30) >> 30;
    n = t >> 24;
    f = t & 64'hFF_FFFF;
    idx = f >> FRAC_SHIFT;
    frac = f & ((64'd1 << FRAC_SHIFT) - 1);
    d = (exp2_rom[idx] >= exp2_rom[idx+1]) ? exp2_rom[idx] - exp2_rom[idx+1] : 64'd0;
    m = exp2_rom[idx] - ((d * frac) >> FRAC_SHIFT);
    e = (n >= 63) ? 64'd0 : m >> n;
    r = (u64_t'(gauss_norm) * e + (Q30_ONE >> 1)) >> 30;
    return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
  endfunction

  // Spread over many magnitudes so that both the tail and the core of the
  // profile are hit, with some fully random words for the high bits.
  function automatic logic [31:0] log_spread_word();
    logic [31:0] v;
    int unsigned w;
    if ($urandom_range(0, 99) < 15) return $urandom;
    w = $urandom_range(0, 26);
    v = $urandom & ((32'd1 << w) - 32'd1);
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  task automatic write_reg(input logic [egpe_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [31:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      egpe_pkg::CFG_COEF_COS: gauss_cos = data;
      egpe_pkg::CFG_COEF_SIN: gauss_sin = data;
      egpe_pkg::CFG_INV_AXIS_RATIO_SQ: gauss_inv_ar2 = data;
      egpe_pkg::CFG_NORM: gauss_norm = data;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [31:0] c, input logic [31:0] s,
                            input logic [31:0] inv_ar2, input logic [31:0] peak);
    write_reg(egpe_pkg::CFG_COEF_COS, c);
    write_reg(egpe_pkg::CFG_COEF_SIN, s);
    write_reg(egpe_pkg::CFG_INV_AXIS_RATIO_SQ, inv_ar2);
    write_reg(egpe_pkg::CFG_NORM, peak);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  task automatic send_pixel(input logic signed [31:0] x, input logic signed [31:0] y);
    while (!steady && $urandom_range(0, 99) < 21) begin
      pixel_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pixel_ch.valid <= 1'b1;
    pixel_ch.dx <= x;
    pixel_ch.dy <= y;
    @(posedge clk);
    while (!pixel_ch.ready) @(posedge clk);
    intensity_q.push_back(predict_intensity(x, y));
    pixels_sent++;
  endtask

  task automatic wait_for_results();
    pixel_ch.valid <= 1'b0;
    while (intensity_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    // Zero norm after reset: every pixel must come out dark.
    send_pixel('0, '0);
    send_pixel(32'h7FFF_FFFF, 32'h8000_0000);
    wait_for_results();
  endtask

  task automatic test_special_cases();
    set_config(Q24_ONE, '0, Q24_ONE, 32'hFFFF_FFFF);
    send_pixel('0, '0);
    send_pixel(32'sh0001_0000, '0);
    send_pixel(-32'sh0001_0000, 32'sh0001_8000);
    send_pixel(32'sd360448, '0);
    // Either side of q = 32, where the exp underflows.
    send_pixel(32'sd370727, '0);
    send_pixel(32'sd370728, '0);
    // Rotated offset just under and exactly at 64.0.
    send_pixel(32'sh003F_FFFF, '0);
    send_pixel(32'sh0040_0000, '0);
    send_pixel('0, -32'sh0040_0000);
    send_pixel(32'h8000_0000, 32'h8000_0000);
    send_pixel(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_pixel(32'h7FFF_FFFF, 32'h8000_0000);
    wait_for_results();
    // Diagonal rotation with the minor axis term switched off.
    set_config(32'h00B5_04F3, 32'h00B5_04F3, '0, 32'h0123_4567);
    send_pixel(32'sh0002_0000, -32'sh0002_0000);
    send_pixel(32'sh0000_8000, 32'sh0001_4000);
    wait_for_results();
  endtask

  task automatic test_unknown_index();
    write_reg(CFG_SPARE_LO, 32'hDEAD_BEEF);
    write_reg(CFG_SPARE_HI, '0);
    cfg_wr_en <= 1'b0;
    send_pixel('0, '0);
    send_pixel(32'sh0001_0000, 32'sh0001_0000);
    wait_for_results();
  endtask

  task automatic test_register_extremes();
    set_config(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pixel('0, '0);
    repeat (20) send_pixel(log_spread_word(), log_spread_word());
    wait_for_results();
    set_config(32'h7FFF_FFFF, 32'h8000_0000, '0, 32'h0000_0001);
    send_pixel('0, '0);
    repeat (20) send_pixel(log_spread_word(), log_spread_word());
    wait_for_results();
    set_config('0, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    repeat (20) send_pixel(log_spread_word(), log_spread_word());
    wait_for_results();
  endtask

  task automatic test_random();
    logic [31:0] inv_ar2;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      steady = (ph == 3);
      case ($urandom_range(0, 3))
        0: inv_ar2 = '0;
        1: inv_ar2 = Q24_ONE;
        2: inv_ar2 = $urandom_range(0, 32'h0400_0000);
        default: inv_ar2 = $urandom;
      endcase
      set_config(log_spread_word(), log_spread_word(), inv_ar2,
                 ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom);
      repeat (ITEMS_PER_PHASE) send_pixel(log_spread_word(), log_spread_word());
      wait_for_results();
    end
    steady = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (intensity_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("intensity %h arrived with no pixel outstanding",
                                     result_ch.intensity);
        end else begin
          want_intensity = intensity_q.pop_front();
          results_seen++;
          if (want_intensity != 0) nonzero_seen++;
          if (result_ch.intensity !== want_intensity) begin
            errors++;
            if (errors <= 10) $display("intensity mismatch: expected %h, got %h",
                                       want_intensity, result_ch.intensity);
          end
        end
      end
      result_ch.ready <= steady || ($urandom_range(0, 99) >= 21);
    end
  end

  // Ends a hung run: too many cycles in a row with no item moving on either side.
  always @(posedge clk) begin
    if (rst || (pixel_ch.valid && pixel_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("elliptical_gaussian_pixel_eval_top_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    pixel_ch.valid <= 1'b0;
    pixel_ch.dx <= '0;
    pixel_ch.dy <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_special_cases();
    test_unknown_index();
    test_register_extremes();
    test_random();

    wait_for_results();
    repeat (20) @(posedge clk);
    $display("Sent %0d pixels under %0d register settings; %0d intensities checked.",
             pixels_sent, settings_used, results_seen);
    $display("%0d of them were nonzero, the rest dark, clipped or underflowed.",
             nonzero_seen);
    if (errors == 0 && intensity_q.size() == 0) begin
      $display("elliptical_gaussian_pixel_eval_top_tb OK");
    end else begin
      $display("elliptical_gaussian_pixel_eval_top_tb NOT OK");
    end
    $finish;
  end

endmodule
